// ===== src/sdls_pkg.sv =====
package sdls_pkg;

  // field widths
  localparam int SAMPLE_W  = 16;
  localparam int OUT_W     = 17;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 17;

  // product of (sample - span low end) and (out_max - out_min), signed
  localparam int PROD_W    = 35;
  // dividend magnitude and quotient width of the serial divider
  localparam int QUO_W     = 33;
  localparam int DIV_STEPS = QUO_W;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  // output clamp bounds
  localparam logic signed [PROD_W-1:0] OUT_LO = -(PROD_W'(65536));
  localparam logic signed [PROD_W-1:0] OUT_HI = PROD_W'(65535);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SPAN_LO    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VOLT_MAX   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_MIN    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_MAX    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_NOISE_BAND = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SAT_MARGIN = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_PEDAL_MODE = 3'd6;

  // controller -> datapath commands
  typedef struct packed {
    logic accept;
    logic mul;
    logic div_init;
    logic div_step;
    logic add;
    logic finish;
  } cmd_t;

  // datapath -> controller status
  typedef struct packed {
    logic upd;
    logic zero_span;
    logic out_busy;
  } sts_t;

endpackage

// ===== src/sdls_ctrl.sv =====
module sdls_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  input  sdls_pkg::sts_t sts,
  output sdls_pkg::cmd_t cmd
);
  import sdls_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_DINIT,
    S_DIV,
    S_ADD,
    S_OUT
  } state_t;

  state_t           state_r;
  logic [CNT_W-1:0] cnt_r;

  assign in_tready = (state_r == S_IDLE);

  // command decode
  always_comb begin
    cmd          = '0;
    cmd.accept   = (state_r == S_IDLE) && in_tvalid;
    cmd.mul      = (state_r == S_MUL);
    cmd.div_init = (state_r == S_DINIT);
    cmd.div_step = (state_r == S_DIV);
    cmd.add      = (state_r == S_ADD);
    cmd.finish   = (state_r == S_OUT) && !sts.out_busy;
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) state_r <= S_MUL;
        end
        S_MUL: begin
          priority if (!sts.upd) state_r <= S_OUT;
          else if (sts.zero_span) state_r <= S_ADD;
          else state_r <= S_DINIT;
        end
        S_DINIT: begin
          cnt_r   <= '0;
          state_r <= S_DIV;
        end
        S_DIV: begin
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == CNT_W'(DIV_STEPS - 1)) state_r <= S_ADD;
        end
        S_ADD: begin
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (!sts.out_busy) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== src/sdls_dp.sv =====
module sdls_dp (
  input  logic                           clk,
  input  logic                           rst_n,
  // configuration writes
  input  logic                           cfg_we,
  input  logic [sdls_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sdls_pkg::CFG_DAT_W-1:0] cfg_data,
  // input sample
  input  logic [sdls_pkg::SAMPLE_W-1:0]  in_sample,
  // result
  input  logic                           out_tready,
  output logic                           out_valid,
  output logic [sdls_pkg::OUT_W-1:0]     out_value,
  output logic                           out_error,
  // control
  input  sdls_pkg::cmd_t                 cmd,
  output sdls_pkg::sts_t                 sts
);
  import sdls_pkg::*;

  // configuration registers
  logic [SAMPLE_W-1:0]     span_lo_r, volt_max_r, noise_band_r, sat_margin_r;
  logic signed [OUT_W-1:0] out_min_r, out_max_r;
  logic                    pedal_mode_r;

  // held state
  logic [SAMPLE_W-1:0]     held_sample_r;
  logic signed [OUT_W-1:0] held_output_r;

  // per-item registers
  logic [SAMPLE_W-1:0]     s_r;
  logic                    err_r, upd_r, snap_lo_r, snap_hi_r;
  logic signed [PROD_W-1:0] prod_r;
  logic [QUO_W-1:0]        dvd_r;
  logic [SAMPLE_W-1:0]     dvs_r, rem_r;
  logic                    neg_r;
  logic signed [OUT_W-1:0] lin_r;

  // output register
  logic                    out_valid_r, out_err_r;
  logic signed [OUT_W-1:0] out_value_r;

  // accept-time decisions
  logic [SAMPLE_W-1:0] diff;
  logic [SAMPLE_W:0]   lo_lim, hi_sum;
  logic                upd_nxt, err_nxt, snap_lo_nxt, snap_hi_nxt;

  assign diff    = (in_sample >= held_sample_r) ? (in_sample - held_sample_r)
                                                : (held_sample_r - in_sample);
  assign upd_nxt = diff > noise_band_r;
  assign err_nxt = !pedal_mode_r && ((in_sample < span_lo_r) || (in_sample > volt_max_r));
  assign lo_lim  = {1'b0, span_lo_r} + {1'b0, sat_margin_r};
  assign hi_sum  = {1'b0, in_sample} + {1'b0, sat_margin_r};
  assign snap_lo_nxt = {1'b0, in_sample} <= lo_lim;
  assign snap_hi_nxt = pedal_mode_r ? (hi_sum >= {1'b0, volt_max_r})
                                    : (in_sample >= volt_max_r);

  // span, offset and range terms
  logic signed [SAMPLE_W:0]   span, offs;
  logic signed [OUT_W:0]      range_v;
  logic signed [PROD_W-1:0]   prod_nxt;

  assign span     = $signed({1'b0, volt_max_r}) - $signed({1'b0, span_lo_r});
  assign offs     = $signed({1'b0, s_r}) - $signed({1'b0, span_lo_r});
  assign range_v  = $signed({out_max_r[OUT_W-1], out_max_r})
                  - $signed({out_min_r[OUT_W-1], out_min_r});
  assign prod_nxt = PROD_W'(offs) * PROD_W'(range_v);

  // restoring divider step, one quotient bit per cycle
  logic [SAMPLE_W:0] shifted;
  logic              ge;

  assign shifted = {rem_r, dvd_r[QUO_W-1]};
  assign ge      = shifted >= {1'b0, dvs_r};

  // signed quotient plus offset, clamped to the signed 17-bit output range; out_min on a zero span
  logic signed [QUO_W:0]    qs;
  logic signed [PROD_W-1:0] sum;
  logic signed [OUT_W-1:0]  lin_nxt;

  assign qs  = neg_r ? -$signed({1'b0, dvd_r}) : $signed({1'b0, dvd_r});
  assign sum = PROD_W'(qs) + PROD_W'(out_min_r);

  always_comb begin
    priority if (sts.zero_span) lin_nxt = out_min_r;
    else if (sum < OUT_LO) lin_nxt = OUT_LO[OUT_W-1:0];
    else if (sum > OUT_HI) lin_nxt = OUT_HI[OUT_W-1:0];
    else lin_nxt = sum[OUT_W-1:0];
  end

  // final selection with end snaps
  logic signed [OUT_W-1:0] res;

  always_comb begin
    priority if (!upd_r) res = held_output_r;
    else if (snap_lo_r) res = out_min_r;
    else if (snap_hi_r) res = out_max_r;
    else res = lin_r;
  end

  // configuration register file
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      span_lo_r    <= '0;
      volt_max_r   <= '1;
      out_min_r    <= '0;
      out_max_r    <= OUT_W'(65535);
      noise_band_r <= '0;
      sat_margin_r <= '0;
      pedal_mode_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SPAN_LO:    span_lo_r    <= cfg_data[SAMPLE_W-1:0];
        REG_VOLT_MAX:   volt_max_r   <= cfg_data[SAMPLE_W-1:0];
        REG_OUT_MIN:    out_min_r    <= cfg_data[OUT_W-1:0];
        REG_OUT_MAX:    out_max_r    <= cfg_data[OUT_W-1:0];
        REG_NOISE_BAND: noise_band_r <= cfg_data[SAMPLE_W-1:0];
        REG_SAT_MARGIN: sat_margin_r <= cfg_data[SAMPLE_W-1:0];
        REG_PEDAL_MODE: pedal_mode_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // held sample and held output
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_sample_r <= '0;
      held_output_r <= '0;
    end else begin
      if (cmd.accept && upd_nxt) held_sample_r <= in_sample;
      if (cmd.finish) held_output_r <= res;
    end
  end

  // arithmetic pipeline and divider
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      s_r       <= in_sample;
      err_r     <= err_nxt;
      upd_r     <= upd_nxt;
      snap_lo_r <= snap_lo_nxt;
      snap_hi_r <= snap_hi_nxt;
    end
    if (cmd.mul) prod_r <= prod_nxt;
    if (cmd.div_init) begin
      dvd_r <= prod_r[PROD_W-1] ? QUO_W'(-prod_r) : prod_r[QUO_W-1:0];
      dvs_r <= span[SAMPLE_W] ? SAMPLE_W'(-span) : span[SAMPLE_W-1:0];
      rem_r <= '0;
      neg_r <= prod_r[PROD_W-1] ^ span[SAMPLE_W];
    end
    if (cmd.div_step) begin
      rem_r <= ge ? SAMPLE_W'(shifted - {1'b0, dvs_r}) : shifted[SAMPLE_W-1:0];
      dvd_r <= {dvd_r[QUO_W-2:0], ge};
    end
    if (cmd.add) lin_r <= lin_nxt;
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_value_r <= res;
      out_err_r   <= err_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_value     = out_value_r;
  assign out_error     = out_err_r;
  assign sts.upd       = upd_r;
  assign sts.zero_span = (span == '0);
  assign sts.out_busy  = out_valid_r && !out_tready;

  // a new result never overwrites one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> !(out_valid_r && !out_tready))
    else $error("result overwritten while output stalled");

  // remainder stays below the divisor through the division
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_step |-> (rem_r < dvs_r))
    else $error("divider remainder out of range");

  // division steps follow an init or another step
  a_div_order: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_step |-> $past(cmd.div_init || cmd.div_step))
    else $error("divider step without init");

  // a sample inside the noise band leaves the held sample alone
  a_deadband_hold: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept && !upd_nxt |=> $stable(held_sample_r))
    else $error("held sample changed inside noise band");

endmodule

// ===== src/sensor_deadband_linear_scaler.sv =====
// Steps from accept to result valid: multiply, output inside the noise band; multiply,
//   add, output with a zero span; multiply, 33-step serial divide, add, output when rescaled.
// Flow: a new sample is taken only after the last result is registered, past any output
//   stall; the bit-serial restoring divider over the span makes one quotient bit per cycle.
// Reset: synchronous active-low rst_n clears control, held sample and held output to zero
//   and loads the register defaults; no clearing pass.
module sensor_deadband_linear_scaler (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] sample
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [16:0] scaled_value, [23:17] zero
  output logic [0:0]  out_tuser,  // [0] range_fault
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [16:0] cfg_data
);
  import sdls_pkg::*;

  cmd_t             cmd;
  sts_t             sts;
  logic [OUT_W-1:0] value;
  logic             error;

  assign cfg_ready = 1'b1;

  sdls_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  sdls_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_sample  (in_tdata),
    .out_tready (out_tready),
    .out_valid  (out_tvalid),
    .out_value  (value),
    .out_error  (error),
    .cmd        (cmd),
    .sts        (sts)
  );

  assign out_tdata = {7'd0, value};
  assign out_tuser = error;

endmodule
